[rtl/owrse_pkg.sv]
// ----------------------------------------------------------------------------
// owrse_pkg - shared types and constants for the 1-Wire search ROM engine
// Item and result layouts, command and status codes, reflected CRC-8 step.
// ----------------------------------------------------------------------------
package owrse_pkg;

  localparam int POS_W    = 7;
  localparam int ROM_W    = 64;
  localparam int CRC_W    = 8;
  localparam int STATUS_W = 3;

  localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PAIR  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_SEARCHING  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_DEVICE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_RESP    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CRC_BAD    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 3'd5;

  typedef struct packed {
    logic command;
    logic device_present;
    logic new_enumeration;
    logic id_bit;
    logic id_bit_complement;
  } item_t;

  typedef struct packed {
    logic                direction;
    logic                write_valid;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [ROM_W-1:0]    rom_code;
    logic [POS_W-1:0]    discrepancy_out;
  } result_t;

  // one step of the reflected CRC-8, data bit shifted in at the low end
  function automatic logic [CRC_W-1:0] crc_bit(logic [CRC_W-1:0] crc, logic b);
    logic fb;
    fb = crc[0] ^ b;
    crc_bit = {1'b0, crc[CRC_W-1:1]} ^ (fb ? CRC_POLY : {CRC_W{1'b0}});
  endfunction

endpackage

[rtl/owrse_core.sv]
// ----------------------------------------------------------------------------
// owrse_core - search state and per-beat decision logic
// Holds the search registers and works out the result of one item in a pass.
// ----------------------------------------------------------------------------
module owrse_core #(
  parameter int ROM_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  owrse_pkg::item_t  item,
  output owrse_pkg::result_t res
);

  localparam logic [owrse_pkg::POS_W-1:0] LAST_POS = owrse_pkg::POS_W'(ROM_BITS);
  localparam logic [owrse_pkg::POS_W-1:0] CRC_END  = owrse_pkg::POS_W'(ROM_BITS - 8);
  localparam int SH_W = $clog2(owrse_pkg::ROM_W);

  logic [owrse_pkg::POS_W-1:0]    last_disc, last_disc_next;
  logic [owrse_pkg::POS_W-1:0]    last_zero, last_zero_next;
  logic [owrse_pkg::POS_W-1:0]    bit_pos, bit_pos_next;
  logic [owrse_pkg::ROM_W-1:0]    rom_shift, rom_shift_next;
  logic [owrse_pkg::CRC_W-1:0]    crc_acc, crc_acc_next;
  logic                           searching, searching_next;

  logic [owrse_pkg::POS_W-1:0]    bit_pos_m1;
  logic [SH_W-1:0]                sh;
  logic                           dir;
  logic                           wv;
  logic                           done;
  logic [owrse_pkg::STATUS_W-1:0] st;

  assign bit_pos_m1 = bit_pos - owrse_pkg::POS_W'(1);
  assign sh         = bit_pos_m1[SH_W-1:0];

  always_comb begin
    last_disc_next = last_disc;
    last_zero_next = last_zero;
    bit_pos_next   = bit_pos;
    rom_shift_next = rom_shift;
    crc_acc_next   = crc_acc;
    searching_next = searching;
    dir            = 1'b0;
    wv             = 1'b0;
    done           = 1'b0;
    st             = owrse_pkg::ST_SEARCHING;
    unique case (item.command)
      owrse_pkg::CMD_START: begin
        if (item.new_enumeration) begin
          last_disc_next = '0;
        end
        if (!item.device_present) begin
          last_disc_next = '0;
          searching_next = 1'b0;
          done           = 1'b1;
          st             = owrse_pkg::ST_NO_DEVICE;
        end else begin
          searching_next = 1'b1;
          bit_pos_next   = owrse_pkg::POS_W'(1);
          last_zero_next = '0;
          crc_acc_next   = '0;
        end
      end
      owrse_pkg::CMD_PAIR: begin
        if (!searching) begin
          st = owrse_pkg::ST_UNEXPECTED;
        end else if (item.id_bit && item.id_bit_complement) begin
          searching_next = 1'b0;
          done           = 1'b1;
          st             = owrse_pkg::ST_NO_RESP;
        end else begin
          if (!item.id_bit && !item.id_bit_complement) begin
            // discrepancy: follow old code below, 1 at, 0 above
            if (bit_pos < last_disc) begin
              dir = rom_shift[sh];
            end else begin
              dir = (bit_pos == last_disc);
            end
            if (!dir) begin
              last_zero_next = bit_pos;
            end
          end else begin
            dir = item.id_bit;
          end
          wv = 1'b1;
          rom_shift_next[sh] = dir;
          if (bit_pos <= CRC_END) begin
            crc_acc_next = owrse_pkg::crc_bit(crc_acc, dir);
          end
          if (bit_pos >= LAST_POS) begin
            last_disc_next = last_zero_next;
            searching_next = 1'b0;
            done           = 1'b1;
            st = (rom_shift_next[ROM_BITS-1 -: owrse_pkg::CRC_W] == crc_acc_next) ?
                 owrse_pkg::ST_FOUND : owrse_pkg::ST_CRC_BAD;
          end else begin
            bit_pos_next = bit_pos + owrse_pkg::POS_W'(1);
          end
        end
      end
    endcase
  end

  assign res.direction       = dir;
  assign res.write_valid     = wv;
  assign res.done_res        = done;
  assign res.status          = st;
  assign res.rom_code        = rom_shift_next;
  assign res.discrepancy_out = last_disc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_disc <= '0;
      last_zero <= '0;
      bit_pos   <= owrse_pkg::POS_W'(1);
      rom_shift <= '0;
      crc_acc   <= '0;
      searching <= 1'b0;
    end else if (acc) begin
      last_disc <= last_disc_next;
      last_zero <= last_zero_next;
      bit_pos   <= bit_pos_next;
      rom_shift <= rom_shift_next;
      crc_acc   <= crc_acc_next;
      searching <= searching_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (bit_pos != '0) && (bit_pos <= LAST_POS))
    else $error("bit position outside the code");

  a_disc_range: assert property (@(posedge clk) disable iff (rst)
    (last_disc <= LAST_POS) && (last_zero <= LAST_POS))
    else $error("discrepancy position outside the code");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (acc && res.done_res) |=> !searching)
    else $error("pass ended but search still running");

endmodule

[rtl/one_wire_rom_search_engine_top.sv]
// ----------------------------------------------------------------------------
// one_wire_rom_search_engine_top - 1-Wire search ROM decision engine
// Master-side search ROM algorithm with CRC-8 check of the found code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat per bus event. A start beat
//   (command 0) reports whether the reset saw a presence pulse and may ask
//   for a fresh enumeration; each pair beat (command 1) carries one id bit
//   and its complement read from the bus.
//   Output channel (out_valid / out_stall): exactly one result beat per input
//   beat, in order: the direction bit to write, the end-of-pass flag, status,
//   the ROM code assembled so far and the last discrepancy.
//   An accepted beat's result is registered in the output register, or in
//   the skid register while the receiver stalls. Throughput is one beat per
//   cycle unless the receiver stalls, set by the single decision stage.
//   Reset clears the search state (no pass running, bit position 1, code and
//   discrepancy zero) and empties the output side.
//   When the receiver stalls, the result holds in the output register and
//   one more beat is taken into a skid register; in_stall rises only once
//   that skid register is full.
// ----------------------------------------------------------------------------
module one_wire_rom_search_engine_top #(
  parameter int ROM_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic                              device_present,
  input  logic                              new_enumeration,
  input  logic                              id_bit,
  input  logic                              id_bit_complement,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              direction,
  output logic                              write_valid,
  output logic                              done_res,
  output logic [owrse_pkg::STATUS_W-1:0]    status,
  output logic [owrse_pkg::ROM_W-1:0]       rom_code,
  output logic [owrse_pkg::POS_W-1:0]       discrepancy_out
);

  owrse_pkg::item_t   item;
  owrse_pkg::result_t res;
  owrse_pkg::result_t out_reg;
  owrse_pkg::result_t skid_reg;
  logic               skid_valid;
  logic               in_acc;
  logic               out_fire;

  // gather the input beat
  assign item.command           = command;
  assign item.device_present    = device_present;
  assign item.new_enumeration   = new_enumeration;
  assign item.id_bit            = id_bit;
  assign item.id_bit_complement = id_bit_complement;

  // stall only once the skid register is occupied
  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;
  assign out_fire = out_valid && !out_stall;

  owrse_core #(
    .ROM_BITS(ROM_BITS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .acc (in_acc),
    .item(item),
    .res (res)
  );

  // control: output register valid and skid valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      // output slot is free: refill from skid first, else from the new beat
      out_valid  <= skid_valid || in_acc;
      skid_valid <= 1'b0;
    end else if (in_acc) begin
      // output held by the receiver: park the new beat
      skid_valid <= 1'b1;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (in_acc) begin
        out_reg <= res;
      end
    end else if (in_acc) begin
      skid_reg <= res;
    end
  end

  assign direction       = out_reg.direction;
  assign write_valid     = out_reg.write_valid;
  assign done_res        = out_reg.done_res;
  assign status          = out_reg.status;
  assign rom_code        = out_reg.rom_code;
  assign discrepancy_out = out_reg.discrepancy_out;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_no_write_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res && (status != owrse_pkg::ST_SEARCHING)) |-> !write_valid)
    else $error("direction write flagged on an error result");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_reg)))
    else $error("stalled result beat changed");

endmodule
